// ===== rtl/core/mrbm_pkg.sv =====
// Shared definitions for the masked RGBA blend-mode unit: channel and weight
// widths, blend mode codes and the stage enable bundle.
// No dependencies.
`default_nettype none

package mrbm_pkg;

	localparam int CHAN_W = 8;
	localparam int WT_W   = 9;
	localparam int MASK_W = 11;
	localparam int MODE_W = 3;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
	localparam logic [CHAN_W-1:0] CHAN_HALF_MAX = 8'd127;
	localparam logic [WT_W-1:0] W_ONE = 9'd256;

	// Blend mode codes. Codes above MODE_ADD all select a linear mix.
	localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SCREEN   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_OVERLAY  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ADD      = 3'd4;

	// Load enables of the four pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage : mrbm_pkg

`default_nettype wire

// ===== rtl/core/mrbm_blend_front.sv =====
// Front half of one color lane: operand product (stage 1) and the rounded
// division by 255 that forms the blend target (stage 2).
// Depends on mrbm_pkg.
`default_nettype none

module mrbm_blend_front
	import mrbm_pkg::*;
(
	input  wire logic              clk,
	input  wire pipe_en_t          en,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [CHAN_W-1:0] base,
	input  wire logic [CHAN_W-1:0] layer,
	output logic      [CHAN_W-1:0] base_s2,
	output logic      [CHAN_W-1:0] target_s2
);

	logic [CHAN_W-1:0] op_a;
	logic [CHAN_W-1:0] op_b;
	logic              dbl;
	logic              inv;
	logic              use_div;
	logic [2*CHAN_W-1:0] prod;

	logic [2*CHAN_W:0] prod_s1;
	logic              inv_s1;
	logic              use_div_s1;
	logic [CHAN_W-1:0] base_s1;
	logic [CHAN_W-1:0] layer_s1;

	logic [2*CHAN_W+1:0] y;
	logic [2*CHAN_W+1:0] y_sum;
	logic [9:0]          q0;
	logic [2*CHAN_W+1:0] rem;
	logic [CHAN_W-1:0]   q;
	logic [CHAN_W-1:0]   target;

	// Screen and the upper half of overlay work on inverted channels.
	always_comb begin
		op_a    = base;
		op_b    = layer;
		dbl     = 1'b0;
		inv     = 1'b0;
		use_div = 1'b1;
		case (mode)
			MODE_MULTIPLY: begin
				use_div = 1'b1;
			end
			MODE_SCREEN: begin
				op_a = ~base;
				op_b = ~layer;
				inv  = 1'b1;
			end
			MODE_OVERLAY: begin
				dbl = 1'b1;
				if (base > CHAN_HALF_MAX) begin
					op_a = ~base;
					op_b = ~layer;
					inv  = 1'b1;
				end
			end
			default: begin
				use_div = 1'b0;
			end
		endcase
	end

	assign prod = {{CHAN_W{1'b0}}, op_a} * {{CHAN_W{1'b0}}, op_b};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1    <= dbl ? {prod, 1'b0} : {1'b0, prod};
			inv_s1     <= inv;
			use_div_s1 <= use_div;
			base_s1    <= base;
			layer_s1   <= layer;
		end
	end

	// Rounded division by 255: estimate with y*(257/65536), then one correction.
	always_comb begin
		y      = {1'b0, prod_s1} + 18'd127;
		y_sum  = y + (y >> 8);
		q0     = y_sum[17:8];
		rem    = y - {q0, 8'b0} + {8'b0, q0};
		q      = (rem[9:0] >= 10'd255) ? (q0[7:0] + 8'd1) : q0[7:0];
		if (!use_div_s1) begin
			target = layer_s1;
		end else if (inv_s1) begin
			target = CHAN_MAX - q;
		end else begin
			target = q;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			base_s2   <= base_s1;
			target_s2 <= target;
		end
	end

endmodule : mrbm_blend_front

`default_nettype wire

// ===== rtl/core/mrbm_mix.sv =====
// Back half of one lane: weighted mix of base and target (stage 3 products,
// stage 4 rounding and saturating add). Depends on mrbm_pkg.
`default_nettype none

module mrbm_mix
	import mrbm_pkg::*;
(
	input  wire logic              clk,
	input  wire pipe_en_t          en,
	input  wire logic              is_add,
	input  wire logic [WT_W-1:0]   weight,
	input  wire logic [CHAN_W-1:0] base,
	input  wire logic [CHAN_W-1:0] target,
	output logic      [CHAN_W-1:0] result_s4
);

	logic [2*CHAN_W+WT_W-CHAN_W-1:0] prod_base;
	logic [2*CHAN_W+WT_W-CHAN_W-1:0] prod_tgt;
	logic [2*CHAN_W-1:0] pa_s3;
	logic [2*CHAN_W-1:0] pb_s3;
	logic [CHAN_W-1:0]   base_s3;
	logic                add_s3;
	logic [2*CHAN_W:0]   acc;
	logic [CHAN_W:0]     scaled;
	logic [CHAN_W:0]     add_sum;
	logic [CHAN_W-1:0]   result;

	assign prod_base = {{WT_W{1'b0}}, base} * {{CHAN_W{1'b0}}, W_ONE - weight};
	assign prod_tgt  = {{WT_W{1'b0}}, target} * {{CHAN_W{1'b0}}, weight};

	// In add mode the base term is dropped and the base is added after rounding.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			pa_s3   <= is_add ? '0 : prod_base[2*CHAN_W-1:0];
			pb_s3   <= prod_tgt[2*CHAN_W-1:0];
			base_s3 <= base;
			add_s3  <= is_add;
		end
	end

	always_comb begin
		acc     = {1'b0, pa_s3} + {1'b0, pb_s3} + 17'd128;
		scaled  = acc[2*CHAN_W:CHAN_W];
		add_sum = {1'b0, base_s3} + scaled;
		if (add_s3) begin
			result = add_sum[CHAN_W] ? CHAN_MAX : add_sum[CHAN_W-1:0];
		end else begin
			result = scaled[CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			result_s4 <= result;
		end
	end

endmodule : mrbm_mix

`default_nettype wire

// ===== rtl/core/masked_rgba_blend_modes_unit.sv =====
// Masked RGBA blend-mode unit. Each input beat carries a base pixel, a layer
// pixel, a blend mode and a signed Q2.8 mask weight; each output beat carries
// the blended pixel. The unit takes one beat every clock while in_stall is low
// and has four register stages: operand multiply, rounded division by 255,
// the two mix multiplies, and the final rounding with the saturating add. A
// full pipeline under output stall raises in_stall; any bubble in the
// pipeline is filled while the output waits.
// Depends on mrbm_pkg, mrbm_blend_front and mrbm_mix.
`default_nettype none

module masked_rgba_blend_modes_unit
	import mrbm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CHAN_W-1:0] base_red,
	input  wire logic [CHAN_W-1:0] base_green,
	input  wire logic [CHAN_W-1:0] base_blue,
	input  wire logic [CHAN_W-1:0] base_alpha,
	input  wire logic [CHAN_W-1:0] layer_red,
	input  wire logic [CHAN_W-1:0] layer_green,
	input  wire logic [CHAN_W-1:0] layer_blue,
	input  wire logic [CHAN_W-1:0] layer_alpha,
	input  wire logic [MODE_W-1:0] req_type,
	input  wire logic signed [MASK_W-1:0] mask_weight,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [CHAN_W-1:0] out_red,
	output logic      [CHAN_W-1:0] out_green,
	output logic      [CHAN_W-1:0] out_blue,
	output logic      [CHAN_W-1:0] out_alpha
);

	// Stage valid flags and the ready chain. A stage loads when it is empty or
	// when the stage after it moves on.
	logic     v_s1, v_s2, v_s3, v_s4;
	logic     rdy1, rdy2, rdy3, rdy4;
	pipe_en_t en;

	assign rdy4 = !v_s4 || !out_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign en.s1 = rdy1;
	assign en.s2 = rdy2;
	assign en.s3 = rdy3;
	assign en.s4 = rdy4;

	assign in_stall  = !rdy1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// The mask is clamped to 0..1.0: negative values give zero, anything
	// above 256 gives exactly 256.
	logic [WT_W-1:0] w_in;

	always_comb begin
		if (mask_weight[MASK_W-1]) begin
			w_in = '0;
		end else if (mask_weight[MASK_W-2:0] > {1'b0, W_ONE}) begin
			w_in = W_ONE;
		end else begin
			w_in = mask_weight[WT_W-1:0];
		end
	end

	// Mode side information travels alongside the color lanes. Alpha is mixed
	// only by normal and the codes above add; the other modes pass base alpha through, which
	// the mix does exactly when its weight is zero.
	logic              alpha_mix;
	logic [WT_W-1:0]   w_s1, w_s2;
	logic              add_s1, add_s2;
	logic              amix_s1, amix_s2;
	logic [CHAN_W-1:0] ba_s1, ba_s2, la_s1, la_s2;
	logic [WT_W-1:0]   w_alpha_s2;

	assign alpha_mix = (req_type == MODE_NORMAL) || (req_type > MODE_ADD);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			w_s1    <= w_in;
			add_s1  <= (req_type == MODE_ADD);
			amix_s1 <= alpha_mix;
			ba_s1   <= base_alpha;
			la_s1   <= layer_alpha;
		end
		if (en.s2) begin
			w_s2    <= w_s1;
			add_s2  <= add_s1;
			amix_s2 <= amix_s1;
			ba_s2   <= ba_s1;
			la_s2   <= la_s1;
		end
	end

	assign w_alpha_s2 = amix_s2 ? w_s2 : '0;

	// Color lanes: blend target formation, then the weighted mix.
	logic [CHAN_W-1:0] b_r_s2, b_g_s2, b_b_s2;
	logic [CHAN_W-1:0] x_r_s2, x_g_s2, x_b_s2;

	mrbm_blend_front u_front_r (
		.clk       (clk),
		.en        (en),
		.mode      (req_type),
		.base      (base_red),
		.layer     (layer_red),
		.base_s2   (b_r_s2),
		.target_s2 (x_r_s2)
	);

	mrbm_blend_front u_front_g (
		.clk       (clk),
		.en        (en),
		.mode      (req_type),
		.base      (base_green),
		.layer     (layer_green),
		.base_s2   (b_g_s2),
		.target_s2 (x_g_s2)
	);

	mrbm_blend_front u_front_b (
		.clk       (clk),
		.en        (en),
		.mode      (req_type),
		.base      (base_blue),
		.layer     (layer_blue),
		.base_s2   (b_b_s2),
		.target_s2 (x_b_s2)
	);

	mrbm_mix u_mix_r (
		.clk       (clk),
		.en        (en),
		.is_add    (add_s2),
		.weight    (w_s2),
		.base      (b_r_s2),
		.target    (x_r_s2),
		.result_s4 (out_red)
	);

	mrbm_mix u_mix_g (
		.clk       (clk),
		.en        (en),
		.is_add    (add_s2),
		.weight    (w_s2),
		.base      (b_g_s2),
		.target    (x_g_s2),
		.result_s4 (out_green)
	);

	mrbm_mix u_mix_b (
		.clk       (clk),
		.en        (en),
		.is_add    (add_s2),
		.weight    (w_s2),
		.base      (b_b_s2),
		.target    (x_b_s2),
		.result_s4 (out_blue)
	);

	// Alpha lane: never an add, target is the layer alpha.
	mrbm_mix u_mix_a (
		.clk       (clk),
		.en        (en),
		.is_add    (1'b0),
		.weight    (w_alpha_s2),
		.base      (ba_s2),
		.target    (la_s2),
		.result_s4 (out_alpha)
	);

`ifndef SYNTHESIS
	// Input is held off only when every stage is full and the output is blocked.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_stall))
		else $error("in_stall raised with a bubble in the pipeline");

	// An accepted beat occupies stage one on the next cycle.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted beat lost at stage one");

	// A blocked stage three keeps its beat.
	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy3) |=> v_s3)
		else $error("stage three dropped a blocked beat");
`endif

endmodule : masked_rgba_blend_modes_unit

`default_nettype wire
